>>> hw/rtl/hmap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmap_pkg
// Shared types and codes of the bucketed hash map.
// ----------------------------------------------------------------------------
package hmap_pkg;

  localparam int unsigned KEY_W = 31;
  localparam int unsigned VAL_W = 31;

  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_GET    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } hmap_req_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             bucket_full;
  } hmap_rsp_t;

  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } hmap_way_t;

endpackage
`default_nettype wire

>>> hw/rtl/hmap_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmap_mod
// Bucket index unit: key modulo the bucket count. A power-of-two count is a
// mask with the index ready in the start cycle; any other count is reduced
// one 4-bit digit per cycle.
// ----------------------------------------------------------------------------
module hmap_mod #(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned BW      = 10
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  input  wire  [hmap_pkg::KEY_W-1:0]    key_i,
  output logic                          valid_o,
  output logic [BW-1:0]                 bucket_o
);
  import hmap_pkg::*;

  localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  if (POW2) begin : g_mask
    assign valid_o = start_i;
    if (BUCKETS == 1) begin : g_one
      assign bucket_o = '0;
    end else begin : g_bits
      assign bucket_o = key_i[BW-1:0];
    end
  end else begin : g_iter
    localparam int unsigned DIG = (KEY_W + 3) / 4;
    localparam int unsigned SW  = DIG * 4;
    localparam int unsigned TW  = BW + 4;
    localparam int unsigned CW  = (DIG > 1) ? $clog2(DIG) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(DIG - 1);

    logic          busy_q, busy_d;
    logic          done_q, done_d;
    logic [CW-1:0] cnt_q, cnt_d;
    logic [BW-1:0] r_q, r_d;
    logic [SW-1:0] sh_q, sh_d;
    logic [TW-1:0] t;
    logic [TW-1:0] bsh;

    always_comb begin
      t = {r_q, sh_q[SW-1 -: 4]};
      for (int k = 3; k >= 0; k--) begin
        bsh = TW'(BUCKETS) << k;
        if (t >= bsh) begin
          t = t - bsh;
        end
      end
    end

    always_comb begin
      busy_d = busy_q;
      done_d = 1'b0;
      cnt_d  = cnt_q;
      r_d    = r_q;
      sh_d   = sh_q;
      if (start_i) begin
        busy_d = 1'b1;
        cnt_d  = '0;
        r_d    = '0;
        sh_d   = SW'(key_i);
      end else if (busy_q) begin
        r_d   = t[BW-1:0];
        sh_d  = sh_q << 4;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        busy_q <= busy_d;
        done_q <= done_d;
        cnt_q  <= cnt_d;
      end
    end

    always_ff @(posedge clk_i) begin
      r_q  <= r_d;
      sh_q <= sh_d;
    end

    assign valid_o  = done_q;
    assign bucket_o = r_q;
  end

endmodule
`default_nettype wire

>>> hw/rtl/hmap_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmap_mem
// Bucket row memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hmap_mem #(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned WAYS    = 4,
  parameter int unsigned BW      = 10
) (
  input  wire                                 clk_i,
  input  wire                                 we_i,
  input  wire  [BW-1:0]                       waddr_i,
  input  hmap_pkg::hmap_way_t [WAYS-1:0]      wdata_i,
  input  wire                                 re_i,
  input  wire  [BW-1:0]                       raddr_i,
  output hmap_pkg::hmap_way_t [WAYS-1:0]      rdata_o
);
  import hmap_pkg::*;

  hmap_way_t [WAYS-1:0] mem_q [BUCKETS];
  hmap_way_t [WAYS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> hw/rtl/hmap_way.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmap_way
// Way compare and row update: matches the key against every way of a bucket
// row, builds the response and the row to write back.
// ----------------------------------------------------------------------------
module hmap_way #(
  parameter int unsigned WAYS = 4
) (
  input  hmap_pkg::hmap_req_t                 req_i,
  input  hmap_pkg::hmap_way_t [WAYS-1:0]      row_i,
  output hmap_pkg::hmap_way_t [WAYS-1:0]      row_o,
  output hmap_pkg::hmap_rsp_t                 rsp_o
);
  import hmap_pkg::*;

  logic [WAYS-1:0]  hit;
  logic [WAYS-1:0]  free;
  logic [WAYS-1:0]  first_free;
  logic             present;
  logic [VAL_W-1:0] hit_val;

  always_comb begin
    logic seen;
    seen    = 1'b0;
    hit_val = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit[w]        = row_i[w].vld && (row_i[w].key == req_i.key);
      free[w]       = !row_i[w].vld;
      first_free[w] = free[w] && !seen;
      seen          = seen || free[w];
      hit_val       = hit_val | (hit[w] ? row_i[w].val : '0);
    end
    present = |hit;
  end

  always_comb begin
    row_o = row_i;
    rsp_o = '0;
    case (req_i.command)
      CMD_PUT: begin
        rsp_o.found       = present;
        rsp_o.bucket_full = !present && !(|free);
        for (int w = 0; w < WAYS; w++) begin
          if (hit[w]) begin
            row_o[w].val = req_i.value;
          end else if (!present && first_free[w]) begin
            row_o[w].vld = 1'b1;
            row_o[w].key = req_i.key;
            row_o[w].val = req_i.value;
          end
        end
      end
      CMD_GET: begin
        rsp_o.found      = present;
        rsp_o.read_value = hit_val;
      end
      CMD_REMOVE: begin
        rsp_o.found = present;
        for (int w = 0; w < WAYS; w++) begin
          if (hit[w]) begin
            row_o[w].vld = 1'b0;
          end
        end
      end
      default: begin
        rsp_o = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/bucketed_hash_map_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bucketed_hash_map_top
// Key-value map of BUCKETS rows with WAYS ways each; put, get and remove.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass, one row per cycle, and takes no
// beat until it ends. Each command then reads its bucket row from a
// single-port-read row memory, compares all ways combinationally and writes
// the row back. With a power-of-two BUCKETS a command is accepted with the
// row read, then compared and written back; any other bucket count adds the
// modulo unit, which reduces the key one 4-bit digit per cycle, before the
// row read. Commands are handled one at a time; the result sits in an output
// register so the next beat is taken while it waits.
// ----------------------------------------------------------------------------
module bucketed_hash_map_top #(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned WAYS    = 4
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  hmap_pkg::hmap_req_t  in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output hmap_pkg::hmap_rsp_t  out_data_o
);
  import hmap_pkg::*;

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [BW-1:0] ROW_LAST = BW'(BUCKETS - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_MOD   = 2'd2;
  localparam logic [1:0] ST_EXEC  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [BW-1:0]        clr_q, clr_d;
  logic [BW-1:0]        bucket_q, bucket_d;
  hmap_req_t            req_q, req_d;
  logic                 out_valid_q, out_valid_d;
  hmap_rsp_t            out_data_q, out_data_d;

  logic                 accept;
  logic                 mod_valid;
  logic [BW-1:0]        mod_bucket;
  logic                 mem_we;
  logic [BW-1:0]        mem_waddr;
  hmap_way_t [WAYS-1:0] mem_wdata;
  hmap_way_t [WAYS-1:0] mem_rdata;
  hmap_way_t [WAYS-1:0] row_new;
  hmap_rsp_t            way_rsp;
  logic                 advance;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign advance    = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  hmap_mod #(
    .BUCKETS (BUCKETS),
    .BW      (BW)
  ) u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .key_i    (in_data_i.key),
    .valid_o  (mod_valid),
    .bucket_o (mod_bucket)
  );

  hmap_mem #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS),
    .BW      (BW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mod_valid),
    .raddr_i (mod_bucket),
    .rdata_o (mem_rdata)
  );

  hmap_way #(
    .WAYS (WAYS)
  ) u_way (
    .req_i (req_q),
    .row_i (mem_rdata),
    .row_o (row_new),
    .rsp_o (way_rsp)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bucket_q;
    mem_wdata = row_new;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (advance) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    bucket_d    = bucket_q;
    req_d       = req_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (mod_valid) begin
      bucket_d = mod_bucket;
    end
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == ROW_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          req_d   = in_data_i;
          state_d = mod_valid ? ST_EXEC : ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_valid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (advance) begin
          out_valid_d = 1'b1;
          out_data_d  = way_rsp;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bucket_q   <= bucket_d;
    req_q      <= req_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire
